### rtl/core/mtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtw_pkg: shared types and constants of the multi-task watchdog
// Register map, reset timeouts, command codes and the result of the shared
// countdown unit.
// ----------------------------------------------------------------------------
package mtw_pkg;

  localparam int NumRegs  = 5;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int TimeoutW = 8;
  localparam int ChanW    = 4;

  localparam logic [CfgDataW-1:0] RegResetVal [NumRegs] = '{
    16'h0203, 16'h0303, 16'h0503, 16'h0502, 16'h0F0F
  };

  typedef enum logic {
    CMD_FEED = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // Result of the shared compare-and-decrement unit
  typedef struct packed {
    logic                expire;
    logic [TimeoutW-1:0] next;
  } dec_res_t;

  // Pick the timeout byte of one channel out of a register word
  function automatic logic [TimeoutW-1:0] pick_byte(logic [CfgDataW-1:0] r,
                                                    logic odd);
    logic [TimeoutW-1:0] b;
    b = odd ? r[CfgDataW-1:TimeoutW] : r[TimeoutW-1:0];
    return b;
  endfunction

  // Timeout of a channel as it stands after reset
  function automatic logic [TimeoutW-1:0] default_timeout(logic [ChanW-1:0] ch);
    logic [CfgDataW-1:0] r;
    r = '0;
    if (ch[ChanW-1:1] < CfgIdxW'(NumRegs)) begin
      r = RegResetVal[ch[ChanW-1:1]];
    end
    return pick_byte(r, ch[0]);
  endfunction

endpackage

### rtl/core/multi_task_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_task_watchdog: multi-channel task watchdog
// Per-channel countdowns fed by tasks and walked by a periodic tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid_i / in_stall_o) carry a command: a feed reloads one
//   channel's countdown from its timeout and gives no result; feeds of
//   channels at or above NUM_CHANNELS are dropped. A tick walks the
//   countdowns with one shared decrement unit, one channel per cycle, and
//   stops at the first channel at one or below. On expiry or a set queue-full
//   flag every countdown reloads, again one channel per cycle.
//   A tick yields one result word (out_valid_o / out_stall_i) once the walk
//   and, on failure, the reload sweep are done. The input stalls while a tick
//   is in work. The result sits in an output register; a stalled result
//   holds, and the next word is taken once that register drains or is being
//   drained. Timeout registers are to be written by the user through
//   cfg_we_i / cfg_index_i / cfg_wdata_i only while idle; the block does not
//   enforce this. Reset loads default timeouts and countdowns.
// ----------------------------------------------------------------------------
module multi_task_watchdog #(
  parameter int NUM_CHANNELS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mtw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mtw_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [mtw_pkg::ChanW-1:0]    channel_i,
  input  logic [2:0]                   queues_full_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         failure_o,
  output logic [mtw_pkg::ChanW-1:0]    expired_channel_o,
  output logic                         queue_overflow_o
);
  import mtw_pkg::*;

  logic [ChanW-1:0]    lookup_ch;
  logic [TimeoutW-1:0] lookup_timeout;

  mtw_cfg_regs u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .lookup_ch_i      (lookup_ch),
    .lookup_timeout_o (lookup_timeout)
  );

  mtw_seq #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .channel_i         (channel_i),
    .queues_full_i     (queues_full_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .failure_o         (failure_o),
    .expired_channel_o (expired_channel_o),
    .queue_overflow_o  (queue_overflow_o),
    .lookup_ch_o       (lookup_ch),
    .lookup_timeout_i  (lookup_timeout)
  );

endmodule

### rtl/core/mtw_dec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtw_dec_unit: shared countdown compare and decrement
// Flags a countdown at one or below as expiring and gives its decrement.
// ----------------------------------------------------------------------------
module mtw_dec_unit (
  input  logic [mtw_pkg::TimeoutW-1:0] value_i,
  output mtw_pkg::dec_res_t            res_o
);
  import mtw_pkg::*;

  // Compare against one and step down in the same unit
  always_comb begin
    res_o.expire = (value_i <= TimeoutW'(1));
    res_o.next   = value_i - TimeoutW'(1);
  end

endmodule

### rtl/core/mtw_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtw_cfg_regs: timeout registers
// Five 16-bit registers, two channel timeouts each, with one lookup port.
// ----------------------------------------------------------------------------
module mtw_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mtw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mtw_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [mtw_pkg::ChanW-1:0]    lookup_ch_i,
  output logic [mtw_pkg::TimeoutW-1:0] lookup_timeout_o
);
  import mtw_pkg::*;

  logic [CfgDataW-1:0] regs_q [NumRegs];
  logic [CfgDataW-1:0] sel_word;

  // Write a register; drop indexes beyond the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= RegResetVal[i];
      end
    end else if (cfg_we_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      regs_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // Look up the timeout byte of one channel
  always_comb begin
    sel_word = '0;
    if (lookup_ch_i[ChanW-1:1] < CfgIdxW'(NumRegs)) begin
      sel_word = regs_q[lookup_ch_i[ChanW-1:1]];
    end
    lookup_timeout_o = pick_byte(sel_word, lookup_ch_i[0]);
  end

endmodule

### rtl/core/mtw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtw_seq: watchdog sequencer
// Holds the countdowns, walks them one channel a cycle through the shared
// decrement unit, sweeps a reload on failure and registers the result word.
// ----------------------------------------------------------------------------
module mtw_seq #(
  parameter int NUM_CHANNELS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [mtw_pkg::ChanW-1:0]    channel_i,
  input  logic [2:0]                   queues_full_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         failure_o,
  output logic [mtw_pkg::ChanW-1:0]    expired_channel_o,
  output logic                         queue_overflow_o,
  output logic [mtw_pkg::ChanW-1:0]    lookup_ch_o,
  input  logic [mtw_pkg::TimeoutW-1:0] lookup_timeout_i
);
  import mtw_pkg::*;

  localparam int CW = $clog2(NUM_CHANNELS);
  localparam logic [CW-1:0] LastIdx = CW'(NUM_CHANNELS - 1);
  localparam logic [ChanW-1:0] NoneCh = ChanW'(NUM_CHANNELS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RELOAD
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       idx_q;
  logic                ovf_q;
  logic [ChanW-1:0]    exp_q;
  logic [TimeoutW-1:0] cnt_q [NUM_CHANNELS];
  logic                out_valid_q;
  logic                out_fail_q;
  logic [ChanW-1:0]    out_exp_q;
  logic                out_ovf_q;
  logic                accept;
  dec_res_t            dec_res;

  // Take a word only in idle with the result register free or draining
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Feed looks up the fed channel, walk and reload the current index
  assign lookup_ch_o = (state_q == ST_IDLE) ? channel_i : ChanW'(idx_q);

  mtw_dec_unit u_dec (
    .value_i (cnt_q[idx_q]),
    .res_o   (dec_res)
  );

  // Sequencer, countdowns and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      exp_q       <= NoneCh;
      out_valid_q <= 1'b0;
      out_fail_q  <= 1'b0;
      out_exp_q   <= NoneCh;
      out_ovf_q   <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt_q[i] <= default_timeout(ChanW'(i));
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (command_i == CMD_TICK) begin
              idx_q   <= '0;
              ovf_q   <= |queues_full_i;
              exp_q   <= NoneCh;
              state_q <= ST_WALK;
            end else if (channel_i < NoneCh) begin
              cnt_q[channel_i[CW-1:0]] <= lookup_timeout_i;
            end
          end
        end
        ST_WALK: begin
          if (dec_res.expire) begin
            // Stop the walk at the first expiring channel
            cnt_q[idx_q] <= '0;
            exp_q        <= ChanW'(idx_q);
            idx_q        <= '0;
            state_q      <= ST_RELOAD;
          end else begin
            cnt_q[idx_q] <= dec_res.next;
            if (idx_q == LastIdx) begin
              idx_q <= '0;
              if (ovf_q) begin
                state_q <= ST_RELOAD;
              end else begin
                out_valid_q <= 1'b1;
                out_fail_q  <= 1'b0;
                out_exp_q   <= exp_q;
                out_ovf_q   <= 1'b0;
                state_q     <= ST_IDLE;
              end
            end else begin
              idx_q <= idx_q + CW'(1);
            end
          end
        end
        ST_RELOAD: begin
          // Reload every countdown, one channel a cycle
          cnt_q[idx_q] <= lookup_timeout_i;
          if (idx_q == LastIdx) begin
            idx_q       <= '0;
            out_valid_q <= 1'b1;
            out_fail_q  <= 1'b1;
            out_exp_q   <= exp_q;
            out_ovf_q   <= ovf_q;
            state_q     <= ST_IDLE;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign failure_o         = out_fail_q;
  assign expired_channel_o = out_exp_q;
  assign queue_overflow_o  = out_ovf_q;

endmodule

### rtl/core/mtw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtw_checker: port-level checks of the watchdog
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module mtw_checker #(
  parameter int NUM_CHANNELS = 10
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         command_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         failure_o,
  input logic [mtw_pkg::ChanW-1:0]    expired_channel_o,
  input logic                         queue_overflow_o
);
  import mtw_pkg::*;

  logic tick_acc;
  logic feed_acc;

  assign tick_acc = in_valid_i && !in_stall_o && (command_i == CMD_TICK);
  assign feed_acc = in_valid_i && !in_stall_o && (command_i == CMD_FEED);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(failure_o)
      && $stable(expired_channel_o) && $stable(queue_overflow_o))
    else $error("stalled result word changed");

  // Failure means an expired channel or a queue overflow
  a_fail_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> failure_o == (queue_overflow_o
      || (expired_channel_o != ChanW'(NUM_CHANNELS))))
    else $error("failure flag disagrees with its causes");

  // Expired channel stays within the channel range or the none code
  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> expired_channel_o <= ChanW'(NUM_CHANNELS))
    else $error("expired channel out of range");

  // A tick keeps the input busy on the next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> in_stall_o)
    else $error("input not stalled during tick walk");

  // A feed accepted with no result word pending produces no result word
  a_feed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feed_acc && !out_valid_o |=> !out_valid_o)
    else $error("feed produced a result word");

endmodule

bind multi_task_watchdog mtw_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_mtw_checker (.*);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_task_watchdog
// Drives feed and tick words through the valid/stall input channel, predicts
// every tick result with a scoreboard that keeps its own countdowns and
// timeout registers, and checks each result word field by field. The run
// walks several timeout settings (reset values, all maximum, all minimum,
// zero bytes, short and wide timeouts) with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

  import mtw_pkg::*;

  localparam int NumCh        = 10;
  localparam int RandPerPhase = 125;
  localparam int SettleCycles = 24;
  localparam int IdleLimit    = 2000;

  // Timeout register indexes
  localparam logic [CfgIdxW-1:0] RegT01 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegT89 = 3'd4;

  // Timeout settings walked by the run
  typedef enum int {
    SET_RESET, SET_MAX, SET_MIN, SET_ZERO_MIX, SET_SHORT, SET_WIDE
  } setting_e;

  typedef struct packed {
    logic             failure;
    logic [ChanW-1:0] chan;
    logic             overflow;
  } verdict_t;

  // Directed words: {command, channel, queues_full}
  localparam logic [7:0] Directed [25] = '{
    {CMD_TICK, 4'd0, 3'd0},  {CMD_FEED, 4'd15, 3'd7}, {CMD_FEED, 4'd10, 3'd0},
    {CMD_TICK, 4'd15, 3'd0}, {CMD_TICK, 4'd0, 3'd1},  {CMD_TICK, 4'd0, 3'd2},
    {CMD_TICK, 4'd0, 3'd4},  {CMD_TICK, 4'd0, 3'd0},  {CMD_TICK, 4'd9, 3'd7},
    {CMD_FEED, 4'd0, 3'd7},  {CMD_FEED, 4'd1, 3'd0},  {CMD_FEED, 4'd2, 3'd5},
    {CMD_FEED, 4'd3, 3'd0},  {CMD_FEED, 4'd4, 3'd2},  {CMD_FEED, 4'd5, 3'd0},
    {CMD_FEED, 4'd6, 3'd1},  {CMD_FEED, 4'd7, 3'd0},  {CMD_FEED, 4'd8, 3'd4},
    {CMD_FEED, 4'd9, 3'd0},  {CMD_FEED, 4'd0, 3'd0},  {CMD_FEED, 4'd1, 3'd0},
    {CMD_TICK, 4'd0, 3'd0},  {CMD_FEED, 4'd0, 3'd0},  {CMD_FEED, 4'd1, 3'd0},
    {CMD_TICK, 4'd0, 3'd0}
  };

  // Predicts tick results from its own countdowns and timeout registers
  class tick_scoreboard;
    logic [CfgDataW-1:0] timeout_reg [NumRegs];
    logic [8:0]          countdown [NumCh];
    verdict_t            verdict_q [$];

    function new();
      timeout_reg = '{16'h0203, 16'h0303, 16'h0503, 16'h0502, 16'h0F0F};
      reload_all();
    endfunction

    function logic [TimeoutW-1:0] timeout_of(int ch);
      logic [CfgDataW-1:0] r;
      r = timeout_reg[ch / 2];
      return (ch % 2) ? r[15:8] : r[7:0];
    endfunction

    function void reload_all();
      for (int i = 0; i < NumCh; i++) countdown[i] = {1'b0, timeout_of(i)};
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx < NumRegs) timeout_reg[idx] = data;
    endfunction

    // Apply one accepted word; a tick queues its expected verdict
    function void take_word(cmd_e cmd, logic [ChanW-1:0] ch, logic [2:0] q);
      verdict_t v;
      if (cmd == CMD_FEED) begin
        if (ch < NumCh) countdown[ch] = {1'b0, timeout_of(ch)};
        return;
      end
      v.chan = ChanW'(NumCh);
      v.overflow = |q;
      for (int i = 0; i < NumCh; i++) begin
        if (countdown[i] <= 9'd1) begin
          countdown[i] = '0;
          v.chan = ChanW'(i);
          break;
        end
        countdown[i] = countdown[i] - 9'd1;
      end
      v.failure = (v.chan != ChanW'(NumCh)) || v.overflow;
      if (v.failure) reload_all();
      verdict_q.push_back(v);
    endfunction

    // Compare one result word with the oldest expected verdict
    function string check_verdict(verdict_t got);
      verdict_t want;
      string msg;
      if (verdict_q.size() == 0) begin
        return $sformatf("unexpected result failure=%0b chan=%0d overflow=%0b",
                         got.failure, got.chan, got.overflow);
      end
      want = verdict_q.pop_front();
      msg = "";
      if (got.failure !== want.failure)
        msg = {msg, $sformatf(" failure got %0b exp %0b", got.failure, want.failure)};
      if (got.chan !== want.chan)
        msg = {msg, $sformatf(" expired_channel got %0d exp %0d", got.chan, want.chan)};
      if (got.overflow !== want.overflow)
        msg = {msg, $sformatf(" queue_overflow got %0b exp %0b", got.overflow,
                              want.overflow)};
      return msg;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                command_i     = 1'b0;
  logic [ChanW-1:0]    channel_i     = '0;
  logic [2:0]          queues_full_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic                failure_o;
  logic [ChanW-1:0]    expired_channel_o;
  logic                queue_overflow_o;

  tick_scoreboard sb;
  int  mismatches  = 0;
  int  idle_cycles = 0;
  bit  quiet       = 1'b0;
  int  n_ticks     = 0;
  int  n_feeds     = 0;
  int  n_dropped   = 0;
  int  n_expiries  = 0;
  int  n_overflows = 0;

  multi_task_watchdog #(
    .NUM_CHANNELS(NumCh)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .channel_i,
    .queues_full_i,
    .out_valid_o,
    .out_stall_i,
    .failure_o,
    .expired_channel_o,
    .queue_overflow_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t:%s", $time, msg);
  endtask

  // Write one register and mirror it in the scoreboard
  task automatic program_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Send one word after a random gap and hold it until accepted
  task automatic send_word(cmd_e cmd, logic [ChanW-1:0] ch, logic [2:0] q);
    int gap;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    channel_i     <= ch;
    queues_full_i <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_word(cmd, ch, q);
    if (cmd == CMD_TICK) n_ticks++;
    else if (ch < NumCh) n_feeds++;
    else n_dropped++;
  endtask

  // Wait until every tick result has come, then let the block settle
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result side: random stall per word, check every accepted word
  initial begin : result_sink
    int       stall_left;
    verdict_t got;
    string    msg;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{failure_o, expired_channel_o, queue_overflow_o};
        if (got.chan != ChanW'(NumCh)) n_expiries++;
        if (got.overflow) n_overflows++;
        msg = sb.check_verdict(got);
        if (msg != "") report_mismatch(msg);
        stall_left = quiet ? 0 : $urandom_range(0, 9);
        out_stall_i <= (stall_left != 0);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end
    end
  end

  // Count cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : hang_guard
    wait (idle_cycles >= IdleLimit);
    $display("no handshake for %0d cycles, giving up", IdleLimit);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int                  counted;
    int                  roll;
    int                  lazy;
    logic [ChanW-1:0]    ch;
    logic [2:0]          q;
    logic [CfgDataW-1:0] val;
    logic [7:0]          lo;
    logic [7:0]          hi;
    setting_e            setting;

    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on the reset timeouts
    foreach (Directed[k]) begin
      send_word(cmd_e'(Directed[k][7]), Directed[k][6:3], Directed[k][2:0]);
    end

    for (int s = SET_RESET; s <= SET_WIDE; s++) begin
      setting = setting_e'(s);
      in_valid_i <= 1'b0;
      wait_idle();

      // Reprogram the timeouts and poke the unmapped indexes
      if (setting != SET_RESET) begin
        for (int r = RegT01; r <= RegT89; r++) begin
          case (setting)
            SET_MAX: val = 16'hFFFF;
            SET_MIN: val = 16'h0101;
            SET_ZERO_MIX: begin
              lo = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
              hi = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
              val = {hi, lo};
            end
            SET_SHORT: val = {8'($urandom_range(1, 6)), 8'($urandom_range(1, 6))};
            default: val = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
          endcase
          program_reg(CfgIdxW'(r), val);
        end
        for (int r = NumRegs; r < 2 ** CfgIdxW; r++) begin
          program_reg(CfgIdxW'(r), CfgDataW'($urandom));
        end
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end

      // Tasks feed their channels; one lazy channel may starve
      lazy = $urandom_range(0, NumCh);
      counted = 0;
      while (counted < RandPerPhase) begin
        roll = $urandom_range(0, 99);
        q    = 3'($urandom_range(0, 7));
        ch   = ChanW'($urandom_range(0, 15));
        if (roll < 45) begin
          if ($urandom_range(0, 5) != 0) q = '0;
          send_word(CMD_TICK, ch, q);
        end else if (roll < 88) begin
          do ch = ChanW'($urandom_range(0, NumCh - 1)); while (ch == lazy);
          send_word(CMD_FEED, ch, q);
        end else begin
          send_word(CMD_FEED, ch, q);
        end
        if (roll < 88 || ch < NumCh) counted++;
      end
    end

    in_valid_i <= 1'b0;
    wait_idle();

    $display("covered %0d ticks, %0d feeds and %0d feeds to unused ids",
             n_ticks, n_feeds, n_dropped);
    $display("saw %0d expiries and %0d queue overflows over six timeout settings",
             n_expiries, n_overflows);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
